@@ rtl/core/bap_pkg.sv @@
// ----------------------------------------------------------------------------
// bap_pkg
// Shared types and codes for the advertising data structure parser: record
// kinds, parse phases, AD type codes and configuration register indexes.
// ----------------------------------------------------------------------------
package bap_pkg;

  // record kinds on the result channel
  typedef enum logic [2:0] {
    KIND_NAME      = 3'd0,
    KIND_SERVICE   = 3'd1,
    KIND_MFR       = 3'd2,
    KIND_TXPWR     = 3'd3,
    KIND_DONE      = 3'd4,
    KIND_MALFORMED = 3'd5
  } kind_t;

  // parse phase of the structure walker
  typedef enum logic [1:0] {
    PH_HALT = 2'd0,
    PH_LEN  = 2'd1,
    PH_TYPE = 2'd2,
    PH_DATA = 2'd3
  } phase_t;

  // AD type codes that produce records
  localparam logic [7:0] AD_SERVICE_INC  = 8'h02;
  localparam logic [7:0] AD_SERVICE_CMPL = 8'h03;
  localparam logic [7:0] AD_NAME_SHORT   = 8'h08;
  localparam logic [7:0] AD_NAME_CMPL    = 8'h09;
  localparam logic [7:0] AD_TXPWR        = 8'h0A;
  localparam logic [7:0] AD_MFR          = 8'hFF;

  // configuration register indexes and reset values
  localparam int unsigned CFG_IDX_W = 2;
  localparam logic [CFG_IDX_W-1:0] CFG_NAME_LIMIT    = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_SERVICE_LIMIT = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_MFR_LIMIT     = 2'd2;

  localparam logic [7:0] NAME_LIMIT_RST    = 8'd32;
  localparam logic [6:0] SERVICE_LIMIT_RST = 7'd8;
  localparam logic [7:0] MFR_LIMIT_RST     = 8'd32;

  // result queue geometry
  localparam int unsigned QDEPTH = 4;
  localparam int unsigned QPTR_W = 2;
  localparam int unsigned QCNT_W = 3;

  // one result record
  typedef struct packed {
    kind_t       kind;
    logic [7:0]  idx;
    logic [15:0] val;
    logic        last;
  } rec_t;

endpackage

@@ rtl/core/ble_adv_structure_parser.sv @@
// ----------------------------------------------------------------------------
// ble_adv_structure_parser
// Streaming walker over the length-type-value structures of an advertising
// or scan response buffer, one payload byte per transfer.
// ----------------------------------------------------------------------------
// Usage:
//   in_*  channel: one payload byte per transfer; in_start_req marks the
//         first byte of a buffer and carries in_buffer_length with it.
//   out_* channel: result records (name char, service uuid, manufacturer
//         byte, tx power, structure done, malformed stop); out_last_of_run
//         flags the last record caused by one input byte.
//   cfg_* port: single-cycle writes of name, service and manufacturer
//         limits; the user must write them only while the block is idle (not enforced).
// Order: a byte's records enter the result queue when it is taken and reach out_*
//   after older records drain. A byte updates the parse state when it is taken.
// Throughput: one byte per cycle while the receiver keeps up; a byte that
//   closes a structure with a data record gives two records, which drain one
//   per cycle through the four-entry result queue. in_ready is high while
//   the queue has room for two records.
// Reset: parser halted waiting for a start byte, limits at their defaults,
//   result queue empty.
// Stall: when out_ready is low, records hold in the queue and in_ready drops
//   once fewer than two entries are free; no record is lost.
// ----------------------------------------------------------------------------
module ble_adv_structure_parser (
  input  logic                           clk,
  input  logic                           rst_n,
  // configuration
  input  logic                           cfg_we,
  input  logic [bap_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [7:0]                     cfg_wdata,
  // input byte channel
  input  logic                           in_valid,
  output logic                           in_ready,
  input  logic [7:0]                     in_data_byte,
  input  logic                           in_start_req,
  input  logic [7:0]                     in_buffer_length,
  // result channel
  output logic                           out_valid,
  input  logic                           out_ready,
  output logic [2:0]                     out_kind,
  output logic [7:0]                     out_item_index,
  output logic [15:0]                    out_item_value,
  output logic                           out_last_of_run
);
  import bap_pkg::*;

  // configuration registers
  logic [7:0] name_limit_r;
  logic [6:0] service_limit_r;
  logic [7:0] mfr_limit_r;

  // parse state
  phase_t     phase_r, phase_nxt;
  logic [7:0] pos_r, pos_nxt;
  logic [7:0] total_r, total_nxt;
  logic [7:0] left_r, left_nxt;
  logic [7:0] type_r, type_nxt;
  logic [7:0] di_r, di_nxt;
  logic [7:0] uuid_lo_r, uuid_lo_nxt;

  // result queue
  rec_t              q_mem [QDEPTH];
  logic [QPTR_W-1:0] wr_ptr_r, rd_ptr_r;
  logic [QCNT_W-1:0] count_r;

  logic in_xfer, out_xfer;

  // working values for the current byte
  phase_t     eff_phase;
  logic [7:0] eff_pos, eff_total, pos_inc;
  logic       has_data, has_end;
  rec_t       data_rec, end_rec, rec_a, rec_b;
  logic [1:0] n_rec;

  assign in_xfer  = in_valid && in_ready;
  assign out_xfer = out_valid && out_ready;
  assign in_ready = (count_r <= QCNT_W'(QDEPTH - 2));

  // kept count of the structure with the given type and data index
  function automatic logic [7:0] kept_count(input logic [7:0] t, input logic [7:0] di,
                                            input logic [7:0] nl, input logic [6:0] sl,
                                            input logic [7:0] ml);
    logic [7:0] lim;
    logic [6:0] half;
    logic [7:0] res;
    lim  = (nl == 8'd0) ? 8'd0 : nl - 8'd1;
    half = di[7:1];
    res  = 8'd0;
    if (t == AD_NAME_SHORT || t == AD_NAME_CMPL) begin
      res = (di < lim) ? di : lim;
    end else if (t == AD_SERVICE_INC || t == AD_SERVICE_CMPL) begin
      res = {1'b0, ((half < sl) ? half : sl)};
    end else if (t == AD_MFR) begin
      res = (di < ml) ? di : ml;
    end else if (t == AD_TXPWR) begin
      res = (di != 8'd0) ? 8'd1 : 8'd0;
    end
    return res;
  endfunction

  // configuration writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      name_limit_r    <= NAME_LIMIT_RST;
      service_limit_r <= SERVICE_LIMIT_RST;
      mfr_limit_r     <= MFR_LIMIT_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_NAME_LIMIT:    name_limit_r    <= cfg_wdata;
        CFG_SERVICE_LIMIT: service_limit_r <= cfg_wdata[6:0];
        CFG_MFR_LIMIT:     mfr_limit_r     <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // parse step for one byte
  always_comb begin
    logic [7:0] name_lim;
    logic [8:0] reach;
    logic [7:0] di_inc;

    eff_total = in_start_req ? in_buffer_length : total_r;
    eff_pos   = in_start_req ? 8'd0 : pos_r;
    if (in_start_req) begin
      eff_phase = (in_buffer_length != 8'd0) ? PH_LEN : PH_HALT;
    end else begin
      eff_phase = phase_r;
    end
    pos_inc  = eff_pos + 8'd1;
    name_lim = (name_limit_r == 8'd0) ? 8'd0 : name_limit_r - 8'd1;
    reach    = {1'b0, pos_inc} + {1'b0, in_data_byte};
    di_inc   = di_r + 8'd1;

    phase_nxt   = eff_phase;
    pos_nxt     = eff_pos;
    total_nxt   = eff_total;
    left_nxt    = left_r;
    type_nxt    = type_r;
    di_nxt      = di_r;
    uuid_lo_nxt = uuid_lo_r;

    has_data = 1'b0;
    has_end  = 1'b0;
    data_rec = '{kind: KIND_NAME, idx: di_r, val: {8'd0, in_data_byte}, last: 1'b0};
    end_rec  = '{kind: KIND_DONE, idx: 8'd0, val: {8'd0, type_r}, last: 1'b0};

    case (eff_phase)
      PH_LEN: begin
        pos_nxt = pos_inc;
        if (in_data_byte == 8'd0 || reach > {1'b0, eff_total}) begin
          has_end      = 1'b1;
          end_rec.kind = KIND_MALFORMED;
          end_rec.idx  = eff_pos;
          end_rec.val  = {8'd0, in_data_byte};
          phase_nxt    = PH_HALT;
        end else begin
          left_nxt  = in_data_byte;
          phase_nxt = PH_TYPE;
        end
      end
      PH_TYPE: begin
        pos_nxt     = pos_inc;
        type_nxt    = in_data_byte;
        left_nxt    = left_r - 8'd1;
        di_nxt      = 8'd0;
        uuid_lo_nxt = 8'd0;
        if (left_r == 8'd1) begin
          // empty structure: done with nothing kept
          has_end     = 1'b1;
          end_rec.val = {8'd0, in_data_byte};
          phase_nxt   = (pos_inc >= eff_total) ? PH_HALT : PH_LEN;
        end else begin
          phase_nxt = PH_DATA;
        end
      end
      PH_DATA: begin
        pos_nxt = pos_inc;
        if (type_r == AD_NAME_SHORT || type_r == AD_NAME_CMPL) begin
          has_data = (di_r < name_lim);
        end else if (type_r == AD_SERVICE_INC || type_r == AD_SERVICE_CMPL) begin
          if (di_r[0]) begin
            has_data      = (di_r[7:1] < service_limit_r);
            data_rec.kind = KIND_SERVICE;
            data_rec.idx  = {1'b0, di_r[7:1]};
            data_rec.val  = {in_data_byte, uuid_lo_r};
          end else begin
            uuid_lo_nxt = in_data_byte;
          end
        end else if (type_r == AD_MFR) begin
          has_data      = (di_r < mfr_limit_r);
          data_rec.kind = KIND_MFR;
        end else if (type_r == AD_TXPWR) begin
          has_data      = (di_r == 8'd0);
          data_rec.kind = KIND_TXPWR;
          data_rec.idx  = 8'd0;
        end
        di_nxt   = di_inc;
        left_nxt = left_r - 8'd1;
        if (left_r == 8'd1) begin
          has_end     = 1'b1;
          end_rec.idx = kept_count(type_r, di_inc, name_limit_r, service_limit_r,
                                   mfr_limit_r);
          phase_nxt   = (pos_inc >= eff_total) ? PH_HALT : PH_LEN;
        end
      end
      default: ;
    endcase

    // order records: data first, then the closing record
    n_rec = {1'b0, has_data} + {1'b0, has_end};
    rec_a = has_data ? data_rec : end_rec;
    rec_a.last = (n_rec == 2'd1);
    rec_b = end_rec;
    rec_b.last = 1'b1;
  end

  // parse state registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r   <= PH_HALT;
      pos_r     <= 8'd0;
      total_r   <= 8'd0;
      left_r    <= 8'd0;
      type_r    <= 8'd0;
      di_r      <= 8'd0;
      uuid_lo_r <= 8'd0;
    end else if (in_xfer) begin
      phase_r   <= phase_nxt;
      pos_r     <= pos_nxt;
      total_r   <= total_nxt;
      left_r    <= left_nxt;
      type_r    <= type_nxt;
      di_r      <= di_nxt;
      uuid_lo_r <= uuid_lo_nxt;
    end
  end

  // result queue storage
  always_ff @(posedge clk) begin
    if (in_xfer) begin
      if (n_rec != 2'd0) begin
        q_mem[wr_ptr_r] <= rec_a;
      end
      if (n_rec == 2'd2) begin
        q_mem[wr_ptr_r + QPTR_W'(1)] <= rec_b;
      end
    end
  end

  // result queue pointers and fill count
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (in_xfer) begin
        wr_ptr_r <= wr_ptr_r + QPTR_W'(n_rec);
      end
      if (out_xfer) begin
        rd_ptr_r <= rd_ptr_r + QPTR_W'(1);
      end
      count_r <= count_r + (in_xfer ? QCNT_W'(n_rec) : QCNT_W'(0))
                         - (out_xfer ? QCNT_W'(1) : QCNT_W'(0));
    end
  end

  // result channel
  assign out_valid       = (count_r != '0);
  assign out_kind        = q_mem[rd_ptr_r].kind;
  assign out_item_index  = q_mem[rd_ptr_r].idx;
  assign out_item_value  = q_mem[rd_ptr_r].val;
  assign out_last_of_run = q_mem[rd_ptr_r].last;

  // queue never holds more than its depth
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= QCNT_W'(QDEPTH))
    else $error("result queue fill count beyond depth");

  // fill count follows pushes and pops
  a_count_track: assert property (@(posedge clk) disable iff (!rst_n)
    (in_xfer && n_rec == 2'd0 && !out_xfer) |=> $stable(count_r))
    else $error("fill count moved without a push or pop");

  // a halted parser without start produces nothing
  a_halt_quiet: assert property (@(posedge clk) disable iff (!rst_n)
    (in_xfer && !in_start_req && phase_r == PH_HALT) |-> (n_rec == 2'd0))
    else $error("record produced while halted");

  // a byte closing a structure leaves the parser at a length byte or halted
  a_close_phase: assert property (@(posedge clk) disable iff (!rst_n)
    (in_xfer && has_end) |=> (phase_r == PH_LEN || phase_r == PH_HALT))
    else $error("parser not at structure boundary after closing record");

endmodule
